// ===== hw/rtl/fntm_pkg.sv =====
// Shared types and constants for the fuzzy name table match block.
package fntm_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEN,
		ST_LENW,
		ST_INIT,
		ST_ROWRD,
		ST_ROWSET,
		ST_CELL,
		ST_NEXT,
		ST_COPY,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic store_we;
		logic len_we;
	} names_we_t;

	typedef struct packed {
		logic pend_we;
		logic row_we;
	} work_we_t;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] VERDICT_GRANTED = 2'd0;
	localparam logic [1:0] VERDICT_SUGGEST = 2'd1;
	localparam logic [1:0] VERDICT_UNKNOWN = 2'd2;

	localparam int IDX_OUT_W  = 6;
	localparam int DIST_OUT_W = 7;

	localparam logic [DIST_OUT_W-1:0] EMPTY_DISTANCE  = 7'd64;
	localparam logic [DIST_OUT_W-1:0] DIST_SATURATE   = 7'd127;
	localparam logic [DIST_OUT_W-1:0] THRESHOLD_RESET = 7'd3;

endpackage

// ===== hw/rtl/fntm_names.sv =====
// Name table storage: character memory and per-entry length memory.
module fntm_names #(
	parameter int TABLE_ENTRIES = 64,
	parameter int MAX_CHARS     = 64,
	localparam int AW = $clog2(TABLE_ENTRIES * MAX_CHARS),
	localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int LW = $clog2(MAX_CHARS + 1)
) (
	input  logic                    clk,
	input  fntm_pkg::names_we_t     we,
	input  logic [AW-1:0]           store_waddr,
	input  logic [7:0]              store_wdata,
	input  logic [AW-1:0]           store_raddr,
	output logic [7:0]              store_rdata,
	input  logic [EW-1:0]           len_waddr,
	input  logic [LW-1:0]           len_wdata,
	input  logic [EW-1:0]           len_raddr,
	output logic [LW-1:0]           len_rdata
);
	logic [7:0]    store_mem [TABLE_ENTRIES * MAX_CHARS];
	logic [LW-1:0] len_mem   [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (we.store_we) begin
			store_mem[store_waddr] <= store_wdata;
		end
		store_rdata <= store_mem[store_raddr];
	end

	always_ff @(posedge clk) begin
		if (we.len_we) begin
			len_mem[len_waddr] <= len_wdata;
		end
		len_rdata <= len_mem[len_raddr];
	end

endmodule

// ===== hw/rtl/fntm_work.sv =====
// Query buffer, distance row memory and the edit-distance cell update.
module fntm_work #(
	parameter int MAX_CHARS = 64,
	localparam int PIW = $clog2(MAX_CHARS),
	localparam int LW  = $clog2(MAX_CHARS + 1),
	localparam int DW  = LW + 1
) (
	input  logic                clk,
	input  fntm_pkg::work_we_t  we,
	input  logic [PIW-1:0]      pend_waddr,
	input  logic [7:0]          pend_wdata,
	input  logic [PIW-1:0]      pend_raddr,
	output logic [7:0]          pend_rdata,
	input  logic [LW-1:0]       row_waddr,
	input  logic [DW-1:0]       row_wdata,
	input  logic [LW-1:0]       row_raddr,
	output logic [DW-1:0]       row_rdata,
	input  logic [7:0]          pch,
	input  logic [7:0]          sch,
	input  logic [DW-1:0]       diag,
	input  logic [DW-1:0]       left,
	output logic [DW-1:0]       dist_next
);
	logic [7:0]    pend_mem [MAX_CHARS];
	logic [DW-1:0] row_mem  [MAX_CHARS + 1];
	logic [DW-1:0] m1;
	logic [DW-1:0] m2;

	always_ff @(posedge clk) begin
		if (we.pend_we) begin
			pend_mem[pend_waddr] <= pend_wdata;
		end
		pend_rdata <= pend_mem[pend_raddr];
	end

	always_ff @(posedge clk) begin
		if (we.row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		row_rdata <= row_mem[row_raddr];
	end

	// The up value is the row entry just read back from memory.
	always_comb begin
		m1 = (row_rdata < diag) ? row_rdata : diag;
		m2 = (left < m1) ? left : m1;
		dist_next = (pch == sch) ? diag : (m2 + DW'(1));
	end

endmodule

// ===== hw/rtl/fuzzy_name_table_match.sv =====
// Fuzzy name table match: nearest stored name by edit distance, top level.
//
// Strings arrive one byte per transfer; the transfer with last set ends the string and its op
// selects load (0) or query (1). A load stores the string unless it equals a stored entry or the
// table is full; a query returns one result: granted on an exact match, a suggestion when the
// smallest edit distance is within the threshold register, otherwise unknown. Ties go to the lowest
// table index. Characters beyond MAX_CHARS are dropped. Names, lengths, the query buffer and one
// distance row live in synchronous memories; a single cell unit walks the dynamic-programming
// table one cell per clock. A character that does not end a string leaves the block idle and
// ready for the next. Ending a string walks every stored entry in turn; a load that is stored
// then copies the buffer into the table, and an empty table answers a query without a walk.
// The next transfer is taken once the block is back in its idle state; a finished result
// waits in the output register and does not block loads.
module fuzzy_name_table_match #(
	parameter int TABLE_ENTRIES = 64,
	parameter int MAX_CHARS     = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  verdict,
	output logic [5:0]  entry_index,
	output logic [6:0]  distance,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);
	localparam int LW  = $clog2(MAX_CHARS + 1);
	localparam int DW  = LW + 1;
	localparam int CW  = $clog2(TABLE_ENTRIES + 1);
	localparam int EW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int AW  = $clog2(TABLE_ENTRIES * MAX_CHARS);
	localparam int PIW = $clog2(MAX_CHARS);

	fntm_pkg::state_t state_q, state_d;

	// Control state.
	logic [LW-1:0]  plen_q;
	logic [CW-1:0]  count_q;
	logic           out_valid_q;
	logic [6:0]     thr_q;

	// Walk registers.
	logic           mode_q;
	logic [CW-1:0]  e_q;
	logic [AW-1:0]  base_q;
	logic [LW-1:0]  n_q;
	logic [LW-1:0]  i_q;
	logic [LW:0]    j_q;
	logic [LW-1:0]  j_s1;
	logic           cell_v_s1;
	logic [LW:0]    k_q;
	logic [LW-1:0]  k_s1;
	logic           copy_v_s1;
	logic [7:0]     pch_q;
	logic [DW-1:0]  diag_q;
	logic [DW-1:0]  left_q;
	logic [DW-1:0]  best_q;
	logic [CW-1:0]  bidx_q;
	logic           dup_q;

	// Result register.
	logic [1:0]     verdict_q;
	logic [5:0]     eidx_q;
	logic [6:0]     dist_q;

	// Memory ports.
	fntm_pkg::names_we_t names_we;
	fntm_pkg::work_we_t  work_we;
	logic [AW-1:0]  store_waddr, store_raddr;
	logic [7:0]     store_rdata;
	logic [EW-1:0]  len_raddr;
	logic [LW-1:0]  len_rdata;
	logic [PIW-1:0] pend_raddr;
	logic [7:0]     pend_rdata;
	logic [LW-1:0]  row_waddr, row_raddr;
	logic [DW-1:0]  row_wdata, row_rdata;
	logic [DW-1:0]  dist_next;

	// Helpers.
	logic           accept;
	logic           rows_done;
	logic           cell_last;
	logic           copy_last;
	logic           cell_issue;
	logic           copy_issue;
	logic           more_entries;
	logic           dup_now;
	logic           can_store;
	logic           out_free;
	logic [6:0]     best_sat;
	logic [LW:0]    jm1;

	assign accept       = in_valid & in_ready;
	assign rows_done    = ({1'b0, i_q} + (LW+1)'(1)) == {1'b0, plen_q};
	assign cell_last    = cell_v_s1 && (j_s1 == n_q);
	assign copy_last    = copy_v_s1 && ({1'b0, k_s1} + (LW+1)'(1) == {1'b0, plen_q});
	assign cell_issue   = (state_q == fntm_pkg::ST_CELL) && (j_q <= {1'b0, n_q});
	assign copy_issue   = (state_q == fntm_pkg::ST_COPY) && (k_q < {1'b0, plen_q});
	assign more_entries = ({1'b0, e_q} + (CW+1)'(1)) < {1'b0, count_q};
	assign dup_now      = dup_q || (left_q == '0);
	assign can_store    = !dup_now && (count_q < CW'(TABLE_ENTRIES));
	assign out_free     = !out_valid_q || out_ready;
	assign jm1          = j_q - (LW+1)'(1);
	assign best_sat     = (16'(best_q) > 16'(fntm_pkg::DIST_SATURATE)) ?
		fntm_pkg::DIST_SATURATE : 7'(best_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			fntm_pkg::ST_IDLE: begin
				if (accept && last) begin
					if (count_q != '0) begin
						state_d = fntm_pkg::ST_LEN;
					end else if (op == fntm_pkg::OP_QUERY) begin
						state_d = fntm_pkg::ST_FIN;
					end else begin
						state_d = fntm_pkg::ST_COPY;
					end
				end
			end
			fntm_pkg::ST_LEN:    state_d = fntm_pkg::ST_LENW;
			fntm_pkg::ST_LENW:   state_d = fntm_pkg::ST_INIT;
			fntm_pkg::ST_INIT: begin
				if (j_q == {1'b0, n_q}) begin
					state_d = fntm_pkg::ST_ROWRD;
				end
			end
			fntm_pkg::ST_ROWRD:  state_d = fntm_pkg::ST_ROWSET;
			fntm_pkg::ST_ROWSET: begin
				if (n_q != '0) begin
					state_d = fntm_pkg::ST_CELL;
				end else begin
					state_d = rows_done ? fntm_pkg::ST_NEXT : fntm_pkg::ST_ROWRD;
				end
			end
			fntm_pkg::ST_CELL: begin
				if (cell_last) begin
					state_d = rows_done ? fntm_pkg::ST_NEXT : fntm_pkg::ST_ROWRD;
				end
			end
			fntm_pkg::ST_NEXT: begin
				if (more_entries) begin
					state_d = fntm_pkg::ST_LEN;
				end else if (mode_q == fntm_pkg::OP_QUERY) begin
					state_d = fntm_pkg::ST_FIN;
				end else if (can_store) begin
					state_d = fntm_pkg::ST_COPY;
				end else begin
					state_d = fntm_pkg::ST_IDLE;
				end
			end
			fntm_pkg::ST_COPY: begin
				if (copy_last) begin
					state_d = fntm_pkg::ST_IDLE;
				end
			end
			fntm_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = fntm_pkg::ST_IDLE;
				end
			end
			default: state_d = fntm_pkg::ST_IDLE;
		endcase
	end

	// Outputs and memory controls.
	always_comb begin
		in_ready          = 1'b0;
		names_we.store_we = 1'b0;
		names_we.len_we   = 1'b0;
		work_we.pend_we   = 1'b0;
		work_we.row_we    = 1'b0;
		row_waddr         = j_q[LW-1:0];
		row_wdata         = DW'(j_q);
		pend_raddr        = i_q[PIW-1:0];
		case (state_q)
			fntm_pkg::ST_IDLE: begin
				in_ready        = 1'b1;
				work_we.pend_we = accept && (plen_q < LW'(MAX_CHARS));
			end
			fntm_pkg::ST_INIT: begin
				work_we.row_we = 1'b1;
			end
			fntm_pkg::ST_ROWSET: begin
				work_we.row_we = 1'b1;
				row_waddr      = '0;
				row_wdata      = DW'(i_q) + DW'(1);
			end
			fntm_pkg::ST_CELL: begin
				work_we.row_we = cell_v_s1;
				row_waddr      = j_s1;
				row_wdata      = dist_next;
			end
			fntm_pkg::ST_COPY: begin
				pend_raddr        = k_q[PIW-1:0];
				names_we.store_we = copy_v_s1;
				names_we.len_we   = copy_last;
			end
			default: begin
			end
		endcase
	end

	assign store_raddr = base_q + AW'(jm1);
	assign store_waddr = AW'(count_q * MAX_CHARS) + AW'(k_s1);
	assign len_raddr   = e_q[EW-1:0];
	assign row_raddr   = j_q[LW-1:0];

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fntm_pkg::ST_IDLE;
			plen_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			thr_q       <= fntm_pkg::THRESHOLD_RESET;
			cell_v_s1   <= 1'b0;
			copy_v_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			// A new result may replace one that leaves in the same cycle.
			if ((state_q == fntm_pkg::ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept && (plen_q < LW'(MAX_CHARS))) begin
				plen_q <= plen_q + LW'(1);
			end
			cell_v_s1 <= cell_issue;
			copy_v_s1 <= copy_issue;
			if (copy_last) begin
				count_q <= count_q + CW'(1);
				plen_q  <= '0;
			end
			if ((state_q == fntm_pkg::ST_NEXT) && !more_entries &&
			    (mode_q == fntm_pkg::OP_LOAD) && !can_store) begin
				plen_q <= '0;
			end
			if ((state_q == fntm_pkg::ST_FIN) && out_free) begin
				plen_q <= '0;
			end
		end
	end

	// Walk and result registers.
	always_ff @(posedge clk) begin
		if (cell_issue) begin
			j_s1 <= j_q[LW-1:0];
			j_q  <= j_q + (LW+1)'(1);
		end
		if (copy_issue) begin
			k_s1 <= k_q[LW-1:0];
			k_q  <= k_q + (LW+1)'(1);
		end
		case (state_q)
			fntm_pkg::ST_IDLE: begin
				mode_q <= op;
				e_q    <= '0;
				base_q <= '0;
				best_q <= '1;
				bidx_q <= '0;
				dup_q  <= 1'b0;
				k_q    <= '0;
			end
			fntm_pkg::ST_LENW: begin
				n_q <= len_rdata;
				j_q <= '0;
			end
			fntm_pkg::ST_INIT: begin
				j_q    <= j_q + (LW+1)'(1);
				i_q    <= '0;
				left_q <= DW'(n_q);
			end
			fntm_pkg::ST_ROWSET: begin
				pch_q  <= pend_rdata;
				diag_q <= DW'(i_q);
				left_q <= DW'(i_q) + DW'(1);
				j_q    <= (LW+1)'(1);
				if (n_q == '0) begin
					i_q <= i_q + LW'(1);
				end
			end
			fntm_pkg::ST_CELL: begin
				if (cell_v_s1) begin
					left_q <= dist_next;
					diag_q <= row_rdata;
				end
				if (cell_last) begin
					i_q <= i_q + LW'(1);
				end
			end
			fntm_pkg::ST_NEXT: begin
				// First strict minimum wins, so ties stay on the lowest index.
				if (left_q < best_q) begin
					best_q <= left_q;
					bidx_q <= e_q;
				end
				dup_q  <= dup_now;
				e_q    <= e_q + CW'(1);
				base_q <= base_q + AW'(MAX_CHARS);
				k_q    <= '0;
			end
			fntm_pkg::ST_FIN: begin
				if (out_free) begin
					if (count_q == '0) begin
						verdict_q <= fntm_pkg::VERDICT_UNKNOWN;
						eidx_q    <= '0;
						dist_q    <= fntm_pkg::EMPTY_DISTANCE;
					end else if (best_sat == '0) begin
						verdict_q <= fntm_pkg::VERDICT_GRANTED;
						eidx_q    <= 6'(bidx_q);
						dist_q    <= best_sat;
					end else if (best_sat <= thr_q) begin
						verdict_q <= fntm_pkg::VERDICT_SUGGEST;
						eidx_q    <= 6'(bidx_q);
						dist_q    <= best_sat;
					end else begin
						verdict_q <= fntm_pkg::VERDICT_UNKNOWN;
						eidx_q    <= '0;
						dist_q    <= best_sat;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign entry_index = eidx_q;
	assign distance    = dist_q;

	fntm_names #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.MAX_CHARS(MAX_CHARS)
	) u_names (
		.clk(clk),
		.we(names_we),
		.store_waddr(store_waddr),
		.store_wdata(pend_rdata),
		.store_raddr(store_raddr),
		.store_rdata(store_rdata),
		.len_waddr(count_q[EW-1:0]),
		.len_wdata(plen_q),
		.len_raddr(len_raddr),
		.len_rdata(len_rdata)
	);

	fntm_work #(
		.MAX_CHARS(MAX_CHARS)
	) u_work (
		.clk(clk),
		.we(work_we),
		.pend_waddr(plen_q[PIW-1:0]),
		.pend_wdata(ch),
		.pend_raddr(pend_raddr),
		.pend_rdata(pend_rdata),
		.row_waddr(row_waddr),
		.row_wdata(row_wdata),
		.row_raddr(row_raddr),
		.row_rdata(row_rdata),
		.pch(pch_q),
		.sch(store_rdata),
		.diag(diag_q),
		.left(left_q),
		.dist_next(dist_next)
	);

endmodule

// ===== tb/fuzzy_name_table_match_tb.sv =====
// Testbench for the fuzzy name table match block: directed table plus random name traffic.
module fuzzy_name_table_match_tb;

	localparam int ENTRIES  = 64;
	localparam int CHARS    = 64;
	localparam int WATCHDOG = 900000;
	// A stored load of a long string against a full table runs a long walk with no transfer,
	// so the watchdog adds this settle margin to its limit.
	localparam int SETTLE   = 300000;

	typedef struct packed {
		logic [1:0] verdict;
		logic [5:0] entry_index;
		logic [6:0] distance;
	} verdict_t;

	// One row of the directed table: a string, its op and an optional typed-in answer.
	typedef struct {
		logic      op;
		string     text;
		logic      known;
		verdict_t  answer;
	} vec_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       op = 1'b0;
	logic [7:0] ch = 8'd0;
	logic       last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] verdict;
	logic [5:0] entry_index;
	logic [6:0] distance;
	logic       cfg_we = 1'b0;
	logic [6:0] cfg_wdata = 7'd0;

	// Predictor state: the table of names and the buffer of the string being received.
	logic [7:0] names [ENTRIES][$];
	int         name_count;
	logic [7:0] pend [$];
	logic [6:0] threshold;

	verdict_t   verdicts_due [$];
	int         errors;
	int         idle_cycles;
	int         send_gap_pct;
	int         recv_gap_pct;

	always #10 clk = ~clk;

	fuzzy_name_table_match u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .ch(ch), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.verdict(verdict), .entry_index(entry_index), .distance(distance),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Levenshtein distance between the query buffer and one stored name.
	function automatic int lev_distance(logic [7:0] a [$], logic [7:0] b [$]);
		int row [$];
		int diag;
		int up;
		int m;
		for (int j = 0; j <= b.size(); j++) begin
			row.push_back(j);
		end
		for (int i = 0; i < a.size(); i++) begin
			diag = row[0];
			row[0] = i + 1;
			for (int j = 1; j <= b.size(); j++) begin
				up = row[j];
				if (a[i] == b[j-1]) begin
					row[j] = diag;
				end else begin
					m = diag;
					if (up < m) m = up;
					if (row[j-1] < m) m = row[j-1];
					row[j] = m + 1;
				end
				diag = up;
			end
		end
		return row[b.size()];
	endfunction

	// Advances the predictor by one accepted character; returns 1 when a verdict is due.
	function automatic bit track_char(logic o, logic [7:0] c, logic l, output verdict_t v);
		bit dup;
		int d;
		int best;
		int best_at;
		v = '0;
		if (pend.size() < CHARS) pend.push_back(c);
		if (!l) return 0;
		if (o == fntm_pkg::OP_LOAD) begin
			dup = 0;
			for (int e = 0; e < name_count; e++) begin
				if (lev_distance(pend, names[e]) == 0) dup = 1;
			end
			if (!dup && name_count < ENTRIES) begin
				names[name_count] = pend;
				name_count++;
			end
			pend.delete();
			return 0;
		end
		if (name_count == 0) begin
			v.verdict = fntm_pkg::VERDICT_UNKNOWN;
			v.distance = fntm_pkg::EMPTY_DISTANCE;
		end else begin
			best = 1 << 30;
			best_at = 0;
			for (int e = 0; e < name_count; e++) begin
				d = lev_distance(pend, names[e]);
				if (d < best) begin
					best = d;
					best_at = e;
				end
			end
			if (best > 127) best = 127;
			v.distance = best[6:0];
			if (best == 0) begin
				v.verdict = fntm_pkg::VERDICT_GRANTED;
				v.entry_index = best_at[5:0];
			end else if (best <= threshold) begin
				v.verdict = fntm_pkg::VERDICT_SUGGEST;
				v.entry_index = best_at[5:0];
			end else begin
				v.verdict = fntm_pkg::VERDICT_UNKNOWN;
			end
		end
		pend.delete();
		return 1;
	endfunction

	// Presents one character and holds it until the transfer happens. Valid stays up after
	// the transfer until the next call either idles or presents the next character.
	task automatic send_char(logic o, logic [7:0] c, logic l);
		verdict_t v;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		ch <= c;
		last <= l;
		do @(posedge clk); while (!in_ready);
		if (track_char(o, c, l, v)) verdicts_due.push_back(v);
	endtask

	task automatic send_string(logic o, logic [7:0] s [$]);
		for (int i = 0; i < s.size(); i++) begin
			send_char(o, s[i], i == s.size() - 1);
		end
	endtask

	// Waits out every pending verdict and the tail of any load, then writes the threshold.
	task automatic set_threshold(logic [6:0] value);
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		do @(posedge clk); while (!in_ready);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold = value;
	endtask

	function automatic void text_to_bytes(string t, ref logic [7:0] s [$]);
		s.delete();
		for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
	endfunction

	// Random string of 1..max_len bytes drawn from a narrow or a full alphabet.
	function automatic void random_bytes(int max_len, bit narrow, ref logic [7:0] s [$]);
		int n;
		n = $urandom_range(max_len, 1);
		s.delete();
		for (int i = 0; i < n; i++) begin
			s.push_back(narrow ? 8'(8'h61 + $urandom_range(3)) : 8'($urandom));
		end
	endfunction

	// Checks every verdict transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (verdicts_due.size() == 0) begin
				$error("verdict with nothing expected: %0d %0d %0d",
					verdict, entry_index, distance);
				errors++;
			end else begin
				automatic verdict_t exp_v = verdicts_due.pop_front();
				if (verdict !== exp_v.verdict) begin
					$error("verdict: expected %0d, got %0d", exp_v.verdict, verdict);
					errors++;
				end
				if (entry_index !== exp_v.entry_index) begin
					$error("entry_index: expected %0d, got %0d", exp_v.entry_index, entry_index);
					errors++;
				end
				if (distance !== exp_v.distance) begin
					$error("distance: expected %0d, got %0d", exp_v.distance, distance);
					errors++;
				end
			end
		end
	end

	// The receiver stalls at random in step with the current idling mix.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_gap_pct);
	end

	// Watchdog: counts cycles with no transfer on either channel and no register write.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles > SETTLE + WATCHDOG) begin
			$display("fuzzy_name_table_match_tb: done, errors");
			$finish;
		end
	end

	initial begin
		vec_row_t   vecs [$];
		logic [7:0] s [$];
		logic [7:0] longest [$];
		int         mix;

		errors = 0;
		idle_cycles = 0;
		name_count = 0;
		threshold = fntm_pkg::THRESHOLD_RESET;
		send_gap_pct = 30;
		recv_gap_pct = 82;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows. Answers are typed in only where they are obvious; the rest
		// go through the predictor.
		vecs.push_back('{fntm_pkg::OP_QUERY, "x",      1'b1,
			'{fntm_pkg::VERDICT_UNKNOWN, 6'd0, 7'd64}});
		vecs.push_back('{fntm_pkg::OP_LOAD,  "alice",  1'b0, '0});
		vecs.push_back('{fntm_pkg::OP_LOAD,  "bob",    1'b0, '0});
		vecs.push_back('{fntm_pkg::OP_LOAD,  "alice",  1'b0, '0});
		vecs.push_back('{fntm_pkg::OP_QUERY, "alice",  1'b1,
			'{fntm_pkg::VERDICT_GRANTED, 6'd0, 7'd0}});
		vecs.push_back('{fntm_pkg::OP_QUERY, "bob",    1'b1,
			'{fntm_pkg::VERDICT_GRANTED, 6'd1, 7'd0}});
		vecs.push_back('{fntm_pkg::OP_QUERY, "alicx",  1'b0, '0});
		vecs.push_back('{fntm_pkg::OP_QUERY, "zzzzzz", 1'b0, '0});
		vecs.push_back('{fntm_pkg::OP_LOAD,  "bod",    1'b0, '0});
		vecs.push_back('{fntm_pkg::OP_QUERY, "boe",    1'b0, '0});
		foreach (vecs[i]) begin
			text_to_bytes(vecs[i].text, s);
			send_string(vecs[i].op, s);
			if (vecs[i].known && verdicts_due[$] !== vecs[i].answer) begin
				$error("directed row %0d: predictor disagrees with typed answer", i);
				errors++;
			end
		end

		// Extreme bytes, a mixed-op string whose final op decides, and an overlong string loaded and queried.
		s.delete();
		s.push_back(8'h00);
		s.push_back(8'hFF);
		send_string(fntm_pkg::OP_LOAD, s);
		send_char(fntm_pkg::OP_QUERY, 8'h00, 1'b0);
		send_char(fntm_pkg::OP_LOAD, 8'hFF, 1'b1);
		send_string(fntm_pkg::OP_QUERY, s);
		longest.delete();
		for (int i = 0; i < CHARS + 6; i++) longest.push_back(8'(8'h41 + i % 26));
		send_string(fntm_pkg::OP_LOAD, longest);
		send_string(fntm_pkg::OP_QUERY, longest);

		set_threshold(7'd0);
		text_to_bytes("alicx", s);
		send_string(fntm_pkg::OP_QUERY, s);
		set_threshold(7'd64);
		send_string(fntm_pkg::OP_QUERY, s);
		set_threshold(7'd127);
		send_string(fntm_pkg::OP_QUERY, s);
		set_threshold(7'd2);

		// Random part in three idling phases. Short names over a narrow alphabet
		// make duplicates, ties and near misses common.
		for (int phase = 0; phase < 3; phase++) begin
			send_gap_pct = (phase == 0) ? 30 : (phase == 1) ? 82 : 0;
			recv_gap_pct = (phase == 0) ? 82 : (phase == 1) ? 30 : 0;
			for (int k = 0; k < 40; k++) begin
				mix = $urandom_range(99);
				if (mix < 3) begin
					random_bytes(CHARS + 4, 1'b0, s);
				end else begin
					random_bytes(5, mix < 70, s);
				end
				send_string((mix % 2 == 0) ? fntm_pkg::OP_LOAD : fntm_pkg::OP_QUERY, s);
			end
			set_threshold(7'($urandom_range(5)));
		end

		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("fuzzy_name_table_match_tb: done, clean");
		end else begin
			$display("fuzzy_name_table_match_tb: done, errors");
		end
		$finish;
	end
endmodule
